// File: rtl/char_lcd_nibble_writer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble writer
// Shared property templates, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cln_pkg.sv
// ----------------------------------------------------------------------------
// cln_pkg
// Constants, types and the init command table of the LCD nibble writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cln_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int MAX_RESULTS = 20;

    // Digits actually kept by the decimal converter.
    localparam int DIGITS = (MAX_DIGITS > MAX_RESULTS / 2) ? MAX_RESULTS / 2 : MAX_DIGITS;
    localparam int BCD_W  = 4 * DIGITS;

    localparam int INIT_LEN  = 4;
    localparam int CNT_MAX   = (DIGITS > INIT_LEN) ? DIGITS : INIT_LEN;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int BIT_CNT_W = $clog2(VALUE_BITS);

    localparam int DELAY_W = 20;
    localparam logic [DELAY_W-1:0] SETTLE_RESET = 20'd270000;

    localparam logic [7:0] ASCII_ZERO = 8'd48;

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_CMD  = 2'd1,
        MODE_DATA = 2'd2,
        MODE_UINT = 2'd3
    } t_mode;

    // Controls of the decimal converter, driven by the top level sequencer.
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_bcd_ctrl;

    // Power-up command sequence: 4-bit bus with two lines, clear, entry mode,
    // display on.
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h01;
            2'd2: b = 8'h06;
            2'd3: b = 8'h0C;
            default: b = 8'h28;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/cln_bin2bcd.sv
// ----------------------------------------------------------------------------
// cln_bin2bcd
// Bit-serial binary to BCD converter with a digit shift-out port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cln_bin2bcd (
    input  logic                              i_clk,
    input  cln_pkg::t_bcd_ctrl                i_ctrl,
    input  logic [cln_pkg::VALUE_BITS-1:0]    i_value,
    output logic [3:0]                        o_digit
);

    logic [cln_pkg::VALUE_BITS-1:0] r_bin;
    logic [cln_pkg::VALUE_BITS-1:0] n_bin;
    logic [cln_pkg::BCD_W-1:0]      r_bcd;
    logic [cln_pkg::BCD_W-1:0]      n_bcd;
    logic [cln_pkg::BCD_W-1:0]      w_adj;

    // Add-three correction on every digit ahead of the doubling shift.
    always_comb begin
        for (int k = 0; k < cln_pkg::DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            n_bin = i_value;
            n_bcd = '0;
        end else if (i_ctrl.step) begin
            n_bcd = {w_adj[cln_pkg::BCD_W-2:0], r_bin[cln_pkg::VALUE_BITS-1]};
            n_bin = {r_bin[cln_pkg::VALUE_BITS-2:0], 1'b0};
        end else if (i_ctrl.shift) begin
            n_bcd = {r_bcd[cln_pkg::BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_digit = r_bcd[cln_pkg::BCD_W-1 -: 4];

endmodule

// File: rtl/char_lcd_nibble_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character LCD writer on a 4-bit bus: init sequence, commands, characters
// and unsigned integers printed in decimal.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. It produces a burst of
// enable strobes on o_strobe, one per cycle while a byte is going out, high
// nibble first and then low nibble; the low nibble carries the settle wait
// and o_last marks the final strobe of the word. The receiver cannot stall,
// so every strobe must be captured in the cycle it appears. An integer first
// passes the bit-serial binary to BCD converter, one input bit per cycle,
// then leading zero digits are dropped one per cycle, then each digit goes
// out as a high and a low nibble strobe. The settle delay register is
// written through its own channel, which is always ready; it must only be
// written while busy is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_lcd_nibble_writer_top_macros.svh"

module char_lcd_nibble_writer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_mode,
    input  logic [cln_pkg::VALUE_BITS-1:0]  i_value,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cln_pkg::DELAY_W-1:0]     i_cfg_settle_delay,

    output logic                            o_strobe,
    output logic                            o_reg_select,
    output logic [3:0]                      o_nibble,
    output logic [cln_pkg::DELAY_W-1:0]     o_wait_ticks,
    output logic                            o_last
);

    // Sequencer states: idle, decimal conversion, leading zero removal,
    // strobe emission.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    cln_pkg::t_mode                  r_mode, n_mode;
    logic [7:0]                      r_val8, n_val8;
    logic [cln_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [cln_pkg::BIT_CNT_W-1:0]   r_bits, n_bits;
    logic                            r_half, n_half;
    logic [cln_pkg::DELAY_W-1:0]     r_settle;

    cln_pkg::t_bcd_ctrl              w_ctrl;
    logic [3:0]                      w_digit;
    logic [cln_pkg::CNT_W-1:0]       w_init_pos;
    logic [7:0]                      w_byte;
    logic                            w_final;

    localparam logic [cln_pkg::CNT_W-1:0] CNT_ONE  = cln_pkg::CNT_W'(1);
    localparam logic [cln_pkg::CNT_W-1:0] CNT_INIT = cln_pkg::CNT_W'(cln_pkg::INIT_LEN);
    localparam logic [cln_pkg::CNT_W-1:0] CNT_DIG  = cln_pkg::CNT_W'(cln_pkg::DIGITS);
    localparam logic [cln_pkg::BIT_CNT_W-1:0] BITS_LAST =
        cln_pkg::BIT_CNT_W'(cln_pkg::VALUE_BITS - 1);

    cln_bin2bcd u_bin2bcd (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (i_value),
        .o_digit (w_digit)
    );

    // The settle delay register is the only configuration state.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= cln_pkg::SETTLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_settle <= i_cfg_settle_delay;
        end
    end

    // The byte being sent. Init bytes are picked by how many remain, integer
    // digits always come from the top of the BCD register.
    assign w_init_pos = CNT_INIT - r_cnt;

    always_comb begin
        case (r_mode)
            cln_pkg::MODE_INIT: w_byte = cln_pkg::init_byte(w_init_pos[1:0]);
            cln_pkg::MODE_CMD:  w_byte = r_val8;
            cln_pkg::MODE_DATA: w_byte = r_val8;
            cln_pkg::MODE_UINT: w_byte = cln_pkg::ASCII_ZERO + {4'd0, w_digit};
            default:            w_byte = r_val8;
        endcase
    end

    assign w_final = r_half && (r_cnt == CNT_ONE);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_val8  = r_val8;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_half  = r_half;
        w_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode = cln_pkg::t_mode'(i_mode);
                    n_val8 = i_value[7:0];
                    n_half = 1'b0;
                    n_bits = '0;
                    case (cln_pkg::t_mode'(i_mode))
                        cln_pkg::MODE_INIT: begin
                            n_cnt   = CNT_INIT;
                            n_state = ST_EMIT;
                        end
                        cln_pkg::MODE_UINT: begin
                            w_ctrl.load = 1'b1;
                            n_state     = ST_CONV;
                        end
                        default: begin
                            n_cnt   = CNT_ONE;
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                w_ctrl.step = 1'b1;
                n_bits      = r_bits + 1'b1;
                if (r_bits == BITS_LAST) begin
                    n_cnt   = CNT_DIG;
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros but always keep the last digit.
                if ((w_digit == 4'd0) && (r_cnt != CNT_ONE)) begin
                    w_ctrl.shift = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    if (r_cnt == CNT_ONE) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                        if (r_mode == cln_pkg::MODE_UINT) begin
                            w_ctrl.shift = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_half  <= 1'b0;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_mode  <= cln_pkg::MODE_INIT;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val8 <= n_val8;
    end

    assign busy = (r_state != ST_IDLE);

    // Strobes come straight from the sequencer registers.
    assign o_strobe     = (r_state == ST_EMIT);
    assign o_reg_select = (r_mode == cln_pkg::MODE_DATA) || (r_mode == cln_pkg::MODE_UINT);
    assign o_nibble     = r_half ? w_byte[3:0] : w_byte[7:4];
    assign o_wait_ticks = r_half ? r_settle : '0;
    assign o_last       = o_strobe && w_final;

    `CLN_ASSERT_NEXT(a_last_frees, o_strobe && o_last, !busy, "busy after the final strobe")
    `CLN_ASSERT_NEXT(a_low_follows_high, o_strobe && !r_half, o_strobe && r_half,
        "high nibble not followed by low nibble")
    `CLN_ASSERT_NEXT(a_short_starts, start && !busy && (i_mode != cln_pkg::MODE_UINT),
        o_strobe && !r_half, "command, data or init word did not start strobing")
    `CLN_ASSERT_NOW(a_digit_range, o_strobe && (r_mode == cln_pkg::MODE_UINT),
        w_digit <= 4'd9, "converter produced a digit above nine")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the character LCD nibble writer
// Sends init, command, character and integer words. It predicts the enable
// strobes of each word and compares every strobe on the bus with that
// prediction.
// ----------------------------------------------------------------------------

module tb_top;

    // The bus takes the four power-up commands in this order.
    localparam logic [7:0] POWER_UP_CMDS [4] = '{8'h28, 8'h01, 8'h06, 8'h0C};

    // One enable strobe on the LCD bus, as the bench expects or observes it.
    typedef struct packed {
        logic                        rs;
        logic [3:0]                  nib;
        logic [cln_pkg::DELAY_W-1:0] wait_ticks;
        logic                        last;
    } t_strobe;

    // Expands each accepted word into the strobes it must produce, and
    // checks the strobes seen on the bus against them in order.
    class strobe_tracker;
        logic [cln_pkg::DELAY_W-1:0] settle;
        t_strobe                     pending_strobes[$];
        int                          n_errors;

        function new();
            settle   = cln_pkg::SETTLE_RESET;
            n_errors = 0;
        endfunction

        // A byte goes out high nibble first; only the low nibble carries the
        // settle wait.
        function void push_byte(logic rs, logic [7:0] b, logic is_last);
            pending_strobes.push_back('{rs, b[7:4], '0, 1'b0});
            pending_strobes.push_back('{rs, b[3:0], settle, is_last});
        endfunction

        function void note_word(cln_pkg::t_mode mode,
                                logic [cln_pkg::VALUE_BITS-1:0] value);
            logic [7:0]                     digits [cln_pkg::DIGITS];
            logic [cln_pkg::VALUE_BITS-1:0] rest;
            int                             n;
            case (mode)
                cln_pkg::MODE_INIT: begin
                    for (int i = 0; i < 4; i++)
                        push_byte(1'b0, POWER_UP_CMDS[i], i == 3);
                end
                cln_pkg::MODE_CMD:  push_byte(1'b0, value[7:0], 1'b1);
                cln_pkg::MODE_DATA: push_byte(1'b1, value[7:0], 1'b1);
                default: begin
                    // Zero still prints one digit. Digits beyond the cap are
                    // the most significant ones and are dropped.
                    rest = value;
                    n    = 0;
                    do begin
                        digits[n] = cln_pkg::ASCII_ZERO + 8'(rest % 10);
                        rest      = rest / 10;
                        n++;
                    end while (rest != 0 && n < cln_pkg::DIGITS);
                    for (int i = n - 1; i >= 0; i--)
                        push_byte(1'b1, digits[i], i == 0);
                end
            endcase
        endfunction

        function void check_strobe(t_strobe got);
            t_strobe want;
            if (pending_strobes.size() == 0) begin
                $display("%0t: unexpected strobe: expected none, got rs=%0d nib=%h wait=%0d last=%0d",
                         $time, got.rs, got.nib, got.wait_ticks, got.last);
                n_errors++;
            end else begin
                want = pending_strobes.pop_front();
                if (got !== want) begin
                    $display("%0t: strobe mismatch: expected rs=%0d nib=%h wait=%0d last=%0d",
                             $time, want.rs, want.nib, want.wait_ticks, want.last);
                    $display("%0t:                  actual   rs=%0d nib=%h wait=%0d last=%0d",
                             $time, got.rs, got.nib, got.wait_ticks, got.last);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     i_mode;
    logic [cln_pkg::VALUE_BITS-1:0] i_value;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [cln_pkg::DELAY_W-1:0]    i_cfg_settle_delay;
    logic                           o_strobe;
    logic                           o_reg_select;
    logic [3:0]                     o_nibble;
    logic [cln_pkg::DELAY_W-1:0]    o_wait_ticks;
    logic                           o_last;

    strobe_tracker sb = new();

    char_lcd_nibble_writer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_value            (i_value),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_settle_delay (i_cfg_settle_delay),
        .o_strobe           (o_strobe),
        .o_reg_select       (o_reg_select),
        .o_nibble           (o_nibble),
        .o_wait_ticks       (o_wait_ticks),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // All inputs change on the falling edge, so at the rising edge the bench
    // reads the same values the block does. The register write, the word
    // acceptance and the strobe check are all taken from values present
    // before the edge. A word is noted before any strobe is checked, so a
    // strobe in the same cycle would still find its expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.settle = i_cfg_settle_delay;
            if (start && !busy)
                sb.note_word(cln_pkg::t_mode'(i_mode), i_value);
            if (o_strobe)
                sb.check_strobe('{o_reg_select, o_nibble, o_wait_ticks, o_last});
        end
    end

    // Offers one word and returns at the edge where it is taken. Start is
    // left high, so the next word can follow with no gap; an idle period or
    // the drain lowers it.
    task automatic send_word(cln_pkg::t_mode mode,
                             logic [cln_pkg::VALUE_BITS-1:0] value);
        @(negedge i_clk);
        start   = 1'b1;
        i_mode  = mode;
        i_value = value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Holds off new words until every expected strobe has come and the
    // block is idle. The guard only keeps a broken block from hanging here;
    // any strobe still owed is reported at the end.
    task automatic wait_drained();
        int guard;
        guard = 0;
        idle_sender(1);
        while ((sb.pending_strobes.size() != 0 || busy) && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // The settle register is only written while the block is idle.
    task automatic write_settle(logic [cln_pkg::DELAY_W-1:0] delay);
        @(negedge i_clk);
        i_cfg_valid        = 1'b1;
        i_cfg_settle_delay = delay;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid        = 1'b0;
        i_cfg_settle_delay = '0;
    endtask

    // Integers are drawn so that every digit count shows up, including the
    // boundaries between counts and the top of the range.
    function automatic logic [cln_pkg::VALUE_BITS-1:0] pick_integer();
        logic [cln_pkg::VALUE_BITS-1:0] p;
        p = 1;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9);
            1: return $urandom_range(0, 99999);
            2: begin
                repeat ($urandom_range(1, 9)) p = p * 10;
                return p - $urandom_range(0, 1);
            end
            3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // A stretch of random words. With the given chance the sender goes
    // quiet for a while before a word; the longest gaps reach past the
    // slowest integer. Halfway through, the sender once waits until
    // every strobe owed has come out.
    task automatic run_random(int count, int idle_pct);
        int             pick;
        cln_pkg::t_mode mode;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                wait_drained();
            if ($urandom_range(1, 100) <= idle_pct)
                idle_sender($urandom_range(1, 60));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                mode = cln_pkg::MODE_INIT;
            else if (pick <= 2)
                mode = cln_pkg::MODE_CMD;
            else if (pick <= 4)
                mode = cln_pkg::MODE_DATA;
            else
                mode = cln_pkg::MODE_UINT;
            send_word(mode, (mode == cln_pkg::MODE_UINT) ? pick_integer() :
                            cln_pkg::VALUE_BITS'($urandom));
        end
    endtask

    initial begin
        start              = 1'b0;
        i_mode             = cln_pkg::MODE_INIT;
        i_value            = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_settle_delay = '0;
        i_rst_n            = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words run with the settle delay left at its reset value.
        // Command and character words carry junk in the upper bits, which
        // must be ignored.
        send_word(cln_pkg::MODE_INIT, '0);
        send_word(cln_pkg::MODE_CMD,  32'h0000_0000);
        send_word(cln_pkg::MODE_CMD,  32'h0000_00FF);
        send_word(cln_pkg::MODE_CMD,  32'hFFFF_FF01);
        send_word(cln_pkg::MODE_DATA, 32'h0000_0000);
        send_word(cln_pkg::MODE_DATA, 32'h0000_00FF);
        send_word(cln_pkg::MODE_DATA, 32'hA5A5_A541);
        idle_sender(3);
        // Zero prints a single '0'; the rest walk the digit counts up to the
        // largest unsigned value.
        send_word(cln_pkg::MODE_UINT, 32'd0);
        send_word(cln_pkg::MODE_UINT, 32'd9);
        send_word(cln_pkg::MODE_UINT, 32'd10);
        send_word(cln_pkg::MODE_UINT, 32'd999_999_999);
        send_word(cln_pkg::MODE_UINT, 32'd1_000_000_000);
        send_word(cln_pkg::MODE_UINT, 32'h8000_0000);
        send_word(cln_pkg::MODE_UINT, 32'hFFFF_FFFF);
        send_word(cln_pkg::MODE_UINT, 32'h5555_5555);
        send_word(cln_pkg::MODE_UINT, 32'hAAAA_AAAA);
        idle_sender(40);
        send_word(cln_pkg::MODE_INIT, 32'hFFFF_FFFF);
        send_word(cln_pkg::MODE_CMD,  32'h0000_0028);
        send_word(cln_pkg::MODE_DATA, 32'h1234_5630);

        // Three random phases, each at its own settle delay: both extremes
        // and a random one. The sender first idles rarely, then often, then
        // not at all.
        wait_drained();
        write_settle(20'hF_FFFF);
        run_random(127, 9);

        wait_drained();
        write_settle(20'h0_0000);
        run_random(127, 65);

        wait_drained();
        write_settle(cln_pkg::DELAY_W'($urandom));
        run_random(126, 0);

        // Let the last integer run through the converter and out the bus.
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.pending_strobes.size() != 0) begin
            $display("%0t: %0d expected strobes never came, first expected rs=%0d nib=%h",
                     $time, sb.pending_strobes.size(), sb.pending_strobes[0].rs,
                     sb.pending_strobes[0].nib);
            sb.n_errors++;
        end
        if (sb.n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // The whole run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
